@@ hdl/xmodem_crc_receiver_unit_defines.svh @@
// Assertion macros shared by the XMODEM-CRC receiver RTL.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef XMODEM_CRC_RECEIVER_UNIT_DEFINES_SVH
`define XMODEM_CRC_RECEIVER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define XCR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define XCR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/xcr_pkg.sv @@
// Package for the XMODEM-CRC receiver: protocol characters, codes,
// the result descriptor type and the CRC-16 byte update. No dependencies.
package xcr_pkg;

  // Protocol characters
  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;
  localparam logic [7:0] CH_C   = 8'h43;

  // Request types
  localparam logic [1:0] REQ_BYTE    = 2'd0;
  localparam logic [1:0] REQ_TIMEOUT = 2'd1;
  localparam logic [1:0] REQ_START   = 2'd2;
  localparam logic [1:0] REQ_NONE    = 2'd3;

  // Run status codes
  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_EOT   = 2'd1;
  localparam logic [1:0] ST_HOST  = 2'd2;
  localparam logic [1:0] ST_LIMIT = 2'd3;

  // Image size and packet sizes
  localparam logic [21:0] IMAGE_BYTES = 22'd1048576;
  localparam logic [10:0] SIZE_SHORT  = 11'd128;
  localparam logic [10:0] SIZE_LONG   = 11'd1024;
  localparam logic [15:0] CRC_POLY    = 16'h1021;

  // Result queue geometry
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  // One queued result; twice marks the CAN CAN pair
  typedef struct packed {
    logic        send_valid;
    logic [7:0]  send_byte;
    logic        write_valid;
    logic [19:0] write_address;
    logic [7:0]  write_data;
    logic [1:0]  run_status;
    logic [20:0] committed_length;
    logic        twice;
  } res_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // CRC-16 update over one byte, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ hdl/xmodem_crc_receiver_unit.sv @@
// Top level of the XMODEM-CRC receiver: front, result queue and back.
// Depends on xcr_pkg, xcr_front, xcr_queue and xcr_back.
//
// Usage:
//   Input channel (in_valid/in_stall, in_req_type, in_byte_value) carries one
//   received byte, a receive timeout or a start command per item. Result
//   channel (out_valid/out_stall, out_* fields) returns one item per input
//   item, or two CAN items with out_last on the second when the error limit
//   aborts the transfer. cfg_wr_en/cfg_wr_data write max_errors (reset 3).
// Path: each accepted item's result is written into the result queue, then
//   loaded into the output register when the output is free.
// Throughput: one item per cycle while in_stall is low; the state update and
//   the unrolled CRC-16 of a byte settle in the front within that cycle. An
//   abort occupies the output with two CAN items.
// Reset: synchronous, active low; the transfer restarts at packet 1 with no
//   errors counted and the queue emptied.
// Stall: a stalled output holds its item; the four-entry result queue keeps
//   taking items and in_stall rises only once it is full.
module xmodem_crc_receiver_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_byte_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_send_valid,
  output logic [7:0]  out_send_byte,
  output logic        out_write_valid,
  output logic [19:0] out_write_address,
  output logic [7:0]  out_write_data,
  output logic [1:0]  out_run_status,
  output logic [20:0] out_committed_length,
  output logic        out_last
);
  import xcr_pkg::*;

  res_t      front_res;
  res_t      head;
  q_status_t q_stat;
  logic      take;
  logic      pop;

  assign in_stall = q_stat.full;
  assign take     = in_valid && !q_stat.full;

  xcr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .take        (take),
    .req_type    (in_req_type),
    .byte_value  (in_byte_value),
    .res         (front_res)
  );

  xcr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take),
    .push_data (front_res),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  xcr_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .head                 (head),
    .q_stat               (q_stat),
    .pop                  (pop),
    .out_stall            (out_stall),
    .out_valid            (out_valid),
    .out_send_valid       (out_send_valid),
    .out_send_byte        (out_send_byte),
    .out_write_valid      (out_write_valid),
    .out_write_address    (out_write_address),
    .out_write_data       (out_write_data),
    .out_run_status       (out_run_status),
    .out_committed_length (out_committed_length),
    .out_last             (out_last)
  );

endmodule

@@ hdl/xcr_front.sv @@
// Front part of the XMODEM-CRC receiver: takes each item, runs the packet
// state machine and builds one result descriptor. Depends on xcr_pkg.
module xcr_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  input  logic               take,
  input  logic [1:0]         req_type,
  input  logic [7:0]         byte_value,
  output xcr_pkg::res_t      res
);
  import xcr_pkg::*;

  typedef enum logic [5:0] {
    PH_HEADER = 6'b000001,
    PH_NUMBER = 6'b000010,
    PH_COMPL  = 6'b000100,
    PH_DATA   = 6'b001000,
    PH_CRCHI  = 6'b010000,
    PH_CRCLO  = 6'b100000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  max_errors_r;
  logic [7:0]  expected_r, expected_nxt;
  logic [7:0]  got_number_r, got_number_nxt;
  logic [7:0]  got_compl_r, got_compl_nxt;
  logic        long_r, long_nxt;
  logic [10:0] index_r, index_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_hi_r, crc_hi_nxt;
  logic [7:0]  errors_r, errors_nxt;
  logic        first_r, first_nxt;
  logic [20:0] offset_r, offset_nxt;
  logic [1:0]  status_r, status_nxt;

  logic        err;
  logic [7:0]  err_sat;
  logic [10:0] size;
  logic [10:0] index_inc;
  logic [20:0] addr;
  logic [21:0] end_addr;
  logic [8:0]  num_sum;
  logic        good;

  assign size      = long_r ? SIZE_LONG : SIZE_SHORT;
  assign index_inc = index_r + 11'd1;
  assign addr      = offset_r + {10'd0, index_r};
  assign end_addr  = {1'b0, offset_r} + {11'd0, size};
  assign num_sum   = {1'b0, got_number_r} + {1'b0, got_compl_r};
  assign good      = (got_number_r == expected_r) && (num_sum == 9'd255) &&
                     ({crc_hi_r, byte_value} == crc_r) && (end_addr <= IMAGE_BYTES);
  assign err_sat   = (errors_r == 8'hFF) ? errors_r : errors_r + 8'd1;

  // Classify the item and work out the next state and its result
  always_comb begin
    phase_nxt      = phase_r;
    expected_nxt   = expected_r;
    got_number_nxt = got_number_r;
    got_compl_nxt  = got_compl_r;
    long_nxt       = long_r;
    index_nxt      = index_r;
    crc_nxt        = crc_r;
    crc_hi_nxt     = crc_hi_r;
    errors_nxt     = errors_r;
    first_nxt      = first_r;
    offset_nxt     = offset_r;
    status_nxt     = status_r;
    err            = 1'b0;
    res            = '0;

    if (req_type == REQ_START) begin
      phase_nxt    = PH_HEADER;
      expected_nxt = 8'd1;
      index_nxt    = '0;
      crc_nxt      = '0;
      errors_nxt   = '0;
      first_nxt    = 1'b0;
      offset_nxt   = '0;
      status_nxt   = ST_RUN;
    end else if (req_type == REQ_NONE || status_r != ST_RUN) begin
      // drop: nothing to do
    end else if (req_type == REQ_TIMEOUT) begin
      if (phase_r == PH_HEADER && !first_r) begin
        res.send_valid = 1'b1;
        res.send_byte  = CH_C;
      end else begin
        err = 1'b1;
      end
    end else begin
      case (phase_r)
        PH_HEADER: begin
          if (byte_value == CH_SOH || byte_value == CH_STX) begin
            long_nxt  = (byte_value == CH_STX);
            index_nxt = '0;
            crc_nxt   = '0;
            phase_nxt = PH_NUMBER;
          end else if (byte_value == CH_EOT) begin
            res.send_valid = 1'b1;
            res.send_byte  = CH_ACK;
            status_nxt     = ST_EOT;
          end else if (byte_value == CH_CAN) begin
            status_nxt = ST_HOST;
          end else begin
            err = 1'b1;
          end
        end
        PH_NUMBER: begin
          got_number_nxt = byte_value;
          phase_nxt      = PH_COMPL;
        end
        PH_COMPL: begin
          got_compl_nxt = byte_value;
          phase_nxt     = PH_DATA;
        end
        PH_DATA: begin
          if ({1'b0, addr} < IMAGE_BYTES) begin
            res.write_valid   = 1'b1;
            res.write_address = addr[19:0];
            res.write_data    = byte_value;
          end
          crc_nxt   = crc_byte(crc_r, byte_value);
          index_nxt = index_inc;
          if (index_inc >= size) begin
            phase_nxt = PH_CRCHI;
          end
        end
        PH_CRCHI: begin
          crc_hi_nxt = byte_value;
          phase_nxt  = PH_CRCLO;
        end
        PH_CRCLO: begin
          if (good) begin
            res.send_valid = 1'b1;
            res.send_byte  = CH_ACK;
            expected_nxt   = expected_r + 8'd1;
            offset_nxt     = end_addr[20:0];
            first_nxt      = 1'b1;
            phase_nxt      = PH_HEADER;
          end else begin
            err = 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_HEADER;
        end
      endcase
    end

    // Count an error: NAK, or CAN CAN once the limit is reached
    if (err) begin
      errors_nxt     = err_sat;
      phase_nxt      = PH_HEADER;
      res.send_valid = 1'b1;
      if (err_sat >= max_errors_r) begin
        res.send_byte = CH_CAN;
        res.twice     = 1'b1;
        status_nxt    = ST_LIMIT;
      end else begin
        res.send_byte = CH_NAK;
      end
    end

    res.run_status       = status_nxt;
    res.committed_length = offset_nxt;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      max_errors_r <= 8'd3;
      expected_r   <= 8'd1;
      errors_r     <= '0;
      first_r      <= 1'b0;
      offset_r     <= '0;
      status_r     <= ST_RUN;
    end else begin
      if (cfg_wr_en) begin
        max_errors_r <= cfg_wr_data;
      end
      if (take) begin
        phase_r    <= phase_nxt;
        expected_r <= expected_nxt;
        errors_r   <= errors_nxt;
        first_r    <= first_nxt;
        offset_r   <= offset_nxt;
        status_r   <= status_nxt;
      end
    end
  end

  // Packet payload state, always set before it is read
  always_ff @(posedge clk) begin
    if (take) begin
      got_number_r <= got_number_nxt;
      got_compl_r  <= got_compl_nxt;
      long_r       <= long_nxt;
      index_r      <= index_nxt;
      crc_r        <= crc_nxt;
      crc_hi_r     <= crc_hi_nxt;
    end
  end

endmodule

@@ hdl/xcr_queue.sv @@
// Short result queue between the front and back parts of the receiver.
// Register-based FIFO of result descriptors. Depends on xcr_pkg.
module xcr_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  xcr_pkg::res_t        push_data,
  input  logic                 pop,
  output xcr_pkg::res_t        head,
  output xcr_pkg::q_status_t   q_stat
);
  import xcr_pkg::*;

  res_t            slot_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   count_r;

  assign head         = slot_r[rd_ptr_r];
  assign q_stat.full  = (count_r == Q_AW'(0) + (Q_AW+1)'(Q_DEPTH));
  assign q_stat.empty = (count_r == '0);

  // Store the pushed descriptor
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (Q_AW+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (Q_AW+1)'(1);
      end
    end
  end

endmodule

@@ hdl/xcr_back.sv @@
// Back part of the receiver: drains the result queue into the output
// register, expanding the error-limit abort into two CAN items. Depends on xcr_pkg.
`include "xmodem_crc_receiver_unit_defines.svh"

module xcr_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  xcr_pkg::res_t        head,
  input  xcr_pkg::q_status_t   q_stat,
  output logic                 pop,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic                 out_send_valid,
  output logic [7:0]           out_send_byte,
  output logic                 out_write_valid,
  output logic [19:0]          out_write_address,
  output logic [7:0]           out_write_data,
  output logic [1:0]           out_run_status,
  output logic [20:0]          out_committed_length,
  output logic                 out_last
);
  import xcr_pkg::*;

  res_t out_r;
  logic out_valid_r;
  logic out_last_r;
  logic second_r;
  logic load;
  logic final_copy;

  assign load       = (!out_valid_r || !out_stall) && !q_stat.empty;
  assign final_copy = !head.twice || second_r;
  assign pop        = load && final_copy;

  // Hold payload while stalled, reload when free
  always_ff @(posedge clk) begin
    if (load) begin
      out_r      <= head;
      out_last_r <= final_copy;
    end
  end

  // Output valid and the pending second CAN
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      second_r    <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        second_r    <= !final_copy;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_send_valid       = out_r.send_valid;
  assign out_send_byte        = out_r.send_byte;
  assign out_write_valid      = out_r.write_valid;
  assign out_write_address    = out_r.write_address;
  assign out_write_data       = out_r.write_data;
  assign out_run_status       = out_r.run_status;
  assign out_committed_length = out_r.committed_length;
  assign out_last             = out_last_r;

  `XCR_ASSERT_IMP(a_second_shows_first, second_r, out_valid_r && !out_last_r,
                  "second CAN pending without first copy on output")
  `XCR_ASSERT_NXT(a_pair_completes, out_valid_r && !out_stall && !out_last_r,
                  out_valid_r && out_last_r && out_send_byte == CH_CAN,
                  "abort pair not completed by second CAN")
  `XCR_ASSERT_IMP(a_pop_nonempty, pop, !q_stat.empty,
                  "result queue popped while empty")

endmodule
